// ===== design/pms_pkg.sv =====
package pms_pkg;

  localparam int DEF_MAX_STACKS = 4;
  localparam int DEF_MAX_DEPTH  = 8;

  localparam int VAL_W       = 64;
  localparam int REQ_W       = 2;
  localparam int SEL_W       = 2;
  localparam int STAT_W      = 2;
  localparam int STK_CFG_W   = 3;
  localparam int DEP_CFG_W   = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  // widest sel * depth + count: 3 * 15 + 15 fits in 7 bits
  localparam int ADDR_CALC_W = 7;

  localparam logic [STK_CFG_W-1:0] STACKS_RESET = 3'd4;
  localparam logic [DEP_CFG_W-1:0] DEPTH_RESET  = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STACKS_IN_USE   = 1'd0,
    REG_DEPTH_PER_STACK = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_READ
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_read;
  } dp_stat_t;

endpackage

// ===== design/partitioned_multi_stack_core.sv =====
// Channel   Direction  Handshake               Payload
// request   in         in_valid / in_ready     req_type, stack_sel, push_value
// result    out        out_valid / out_ready   read_value, status, now_empty, now_full
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A push, clear, refused or bad-index request passes from IDLE through EXEC; a pop or
// peek that hits also passes through READ, for the registered read of the shared item
// memory. Each result is registered when the request finishes, and EXEC or READ waits
// while the result register still holds an untaken result. One request is in flight at a time.
// Reset clears the fill counts and restores both config registers; no memory sweep.
// A stalled result holds its register; one more request may be taken and waits.
module partitioned_multi_stack_core
  import pms_pkg::*;
#(
  parameter int MAX_STACKS = DEF_MAX_STACKS,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [SEL_W-1:0]        stack_sel,
  input  logic signed [VAL_W-1:0] push_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] read_value,
  output logic [STAT_W-1:0]       status,
  output logic                    now_empty,
  output logic                    now_full,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pms_datapath #(
    .MAX_STACKS (MAX_STACKS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (req_type),
    .stack_sel  (stack_sel),
    .push_value (push_value),
    .cmd        (cmd),
    .stat       (stat),
    .read_value (read_value),
    .status     (status),
    .now_empty  (now_empty),
    .now_full   (now_full)
  );

`ifndef NO_ASSERTIONS
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in flight");

  a_bad_index_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_BAD_INDEX) |-> (!now_empty && !now_full && read_value == '0))
    else $error("bad index result carries flags or data");
`endif

endmodule

// ===== design/pms_ctrl.sv =====
module pms_ctrl
  import pms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state, state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (stat.need_read) begin
          cmd.rd_issue = 1'b1;
          state_next   = CS_READ;
        end else if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = CS_IDLE;
        end
      end
      CS_READ: begin
        // hold the fetched word until the result register frees up
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
    out_valid_next = cmd.finish || (out_valid && !out_ready);
  end

endmodule

// ===== design/pms_datapath.sv =====
module pms_datapath
  import pms_pkg::*;
#(
  parameter int MAX_STACKS = DEF_MAX_STACKS,
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [SEL_W-1:0]        stack_sel,
  input  logic signed [VAL_W-1:0] push_value,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic signed [VAL_W-1:0] read_value,
  output logic [STAT_W-1:0]       status,
  output logic                    now_empty,
  output logic                    now_full
);

  localparam int STORE = MAX_STACKS * MAX_DEPTH;
  localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int SI_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int DCAP  = (MAX_DEPTH < 15) ? MAX_DEPTH : 15;
  localparam int CNT_W = $clog2(DCAP + 1);

  logic [STK_CFG_W-1:0]    stacks_cfg;
  logic [DEP_CFG_W-1:0]    depth_cfg;
  logic [CNT_W-1:0]        fill_counts [MAX_STACKS];

  req_t                    req_q;
  logic [SEL_W-1:0]        sel_q;
  logic signed [VAL_W-1:0] val_q;
  logic signed [VAL_W-1:0] mem [STORE];
  logic signed [VAL_W-1:0] mem_q;

  logic [SI_W-1:0]         sidx;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [DEP_CFG_W-1:0]    eff_depth;
  logic                    bad;
  logic                    cnt_zero;
  logic                    is_full;
  logic                    is_read_req;
  logic                    need_read;
  logic                    do_write;
  status_t                 status_c;
  logic [ADDR_CALC_W-1:0]  addr_calc;
  logic [AW-1:0]           mem_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      stacks_cfg <= STACKS_RESET;
      depth_cfg  <= DEPTH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STACKS_IN_USE:   stacks_cfg <= cfg_data[STK_CFG_W-1:0];
        REG_DEPTH_PER_STACK: depth_cfg  <= cfg_data[DEP_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_t'(req_type);
      sel_q <= stack_sel;
      val_q <= push_value;
    end
  end

  assign sidx      = SI_W'(sel_q);
  assign eff_depth = (32'(depth_cfg) > 32'(MAX_DEPTH)) ? DEP_CFG_W'(MAX_DEPTH) : depth_cfg;
  assign bad       = (32'(sel_q) >= 32'(MAX_STACKS)) || ({1'b0, sel_q} >= stacks_cfg);
  assign cnt       = bad ? '0 : fill_counts[sidx];
  assign cnt_zero  = (cnt == '0);
  assign is_full   = (DEP_CFG_W'(cnt) >= eff_depth);
  assign is_read_req = (req_q == REQ_POP) || (req_q == REQ_PEEK);
  assign need_read = !bad && is_read_req && !cnt_zero;
  assign do_write  = !bad && (req_q == REQ_PUSH) && !is_full;
  assign stat.need_read = need_read;

  always_comb begin
    cnt_next = cnt;
    status_c = STAT_OK;
    case (req_q)
      REQ_PUSH: begin
        if (is_full) status_c = STAT_FULL;
        else         cnt_next = CNT_W'(cnt + 1'b1);
      end
      REQ_POP: begin
        if (cnt_zero) status_c = STAT_EMPTY;
        else          cnt_next = CNT_W'(cnt - 1'b1);
      end
      REQ_PEEK: begin
        if (cnt_zero) status_c = STAT_EMPTY;
      end
      REQ_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
    if (bad) status_c = STAT_BAD_INDEX;
  end

  // region base plus count; step back one entry for the top on a read
  assign addr_calc = ADDR_CALC_W'(sel_q) * ADDR_CALC_W'(eff_depth) + ADDR_CALC_W'(cnt)
                     - (need_read ? ADDR_CALC_W'(1) : ADDR_CALC_W'(0));
  assign mem_addr  = AW'(addr_calc);

  always_ff @(posedge clk) begin
    if (cmd.finish && do_write) begin
      mem[mem_addr] <= val_q;
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STACKS; i++) begin
        fill_counts[i] <= '0;
      end
    end else if (cmd.finish && !bad) begin
      fill_counts[sidx] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value <= need_read ? mem_q : '0;
      status     <= status_c;
      now_empty  <= !bad && (cnt_next == '0);
      now_full   <= !bad && (DEP_CFG_W'(cnt_next) >= eff_depth);
    end
  end

endmodule
